// ----- sv/odc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package odc_pkg;

    // Sample and result formats.
    localparam int SAMPLE_BITS   = 24;
    localparam int FRACTION_BITS = 16;
    localparam int CFG_W         = 24;
    localparam int OUT_W         = 20;

    // Stream word widths, padded to whole bytes.
    localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Width used to compare samples with the threshold.
    localparam int CMP_W = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;

    // Logarithm datapath: Q1.31 mantissa, 5-bit exponent, 28 fraction bits.
    localparam int MANT_W   = 32;
    localparam int EXP_W    = $clog2(MANT_W);
    localparam int LOG_FRAC = 28;
    localparam int LOG_W    = EXP_W + LOG_FRAC;
    localparam int PROD_W   = 2 * MANT_W;
    localparam int CNT_W    = $clog2(LOG_FRAC + 1);

    // log10(2) in Q0.30, and the rounding of the Q.58 product.
    localparam logic [MANT_W-1:0] LOG10_2_Q30 = MANT_W'(323228497);
    localparam int PROD_FRAC = LOG_FRAC + 30;
    localparam int RND_SHIFT = PROD_FRAC - FRACTION_BITS;
    localparam int RND_W     = PROD_W + 1 - RND_SHIFT;

    // Saturation limits of the result magnitude.
    localparam logic [OUT_W-1:0] POS_MAX = OUT_W'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic [OUT_W-1:0] NEG_MAX = OUT_W'(64'd1 << (OUT_W - 1));

endpackage

`default_nettype wire

// ----- sv/optical_density_converter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Ports                          | Contents
// ---------+-----+--------------------------------+-------------------------------------
// sample   | in  | s_tvalid s_tready s_tdata s_tuser | intensity, record start flag
// density  | out | m_tvalid m_tready m_tdata      | optical density, Q.16 two's complement
// config   | in  | cfg_valid cfg_ready cfg_data   | min_intensity threshold
//
// A sample at or above the threshold yields its word after 5 normalize steps, repeated squaring
// on the shared 33x32 multiplier, then difference, scaling multiply, rounding and output load.
// A record start yields zero after the squaring, since it skips the difference, multiply and
// rounding; any other sample below the threshold goes straight to the output load and yields zero.
// s_tready is high only while idle; the output load waits while a held word is not taken.
// Reset sets the threshold and the latched reference to one; the config port is always ready.
module optical_density_converter_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Sample channel. tdata: intensity [23:0]. tuser: record_start [0].
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [odc_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  wire logic                               s_tuser,
    // Result channel. tdata: optical_density [19:0], zero fill [23:20].
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [odc_pkg::OUT_TDATA_W-1:0]         m_tdata,
    // Threshold register write channel.
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [odc_pkg::CFG_W-1:0]          cfg_data
);
    import odc_pkg::*;

    // The sequencer states, one-hot.
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_NORM  = 7'b0000010,
        ST_SQR   = 7'b0000100,
        ST_DIFF  = 7'b0001000,
        ST_MUL   = 7'b0010000,
        ST_RND   = 7'b0100000,
        ST_WRITE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]    min_reg, min_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [MANT_W-1:0]   m_reg, m_next;
    logic [EXP_W-1:0]    lz_reg, lz_next;
    logic [LOG_FRAC-1:0] f_reg, f_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [LOG_W-1:0]    la_reg, la_next;
    logic [LOG_W-1:0]    mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic [OUT_W-1:0]    sat_reg, sat_next;
    logic                zero_reg, zero_next;
    logic                start_reg, start_next;
    logic [OUT_W-1:0]    od_reg, od_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // Input decode: the effective threshold is never below one.
    logic [CMP_W-1:0] sample;
    logic [CMP_W-1:0] thresh;
    logic             below;
    logic [CMP_W-1:0] log_in;

    // Normalize step.
    logic [EXP_W-1:0]  amt;
    logic [MANT_W-1:0] m_shift;
    logic              top_zero;
    logic [EXP_W-1:0]  e_val;

    // Squaring step.
    logic [MANT_W:0]     mm;
    logic                sq_bit;
    logic [MANT_W-1:0]   sq_norm;
    logic [MANT_W-1:0]   sq_in;
    logic [LOG_FRAC-1:0] f_shift;
    logic [LOG_W-1:0]    lb;

    // Shared multiplier.
    logic [LOG_W-1:0]        mul_a;
    logic [MANT_W-1:0]       mul_b;
    logic [LOG_W+MANT_W-1:0] mul_p;

    // Rounding.
    logic [PROD_W:0]    rnd_sum;
    logic [RND_W-1:0]   rnd;
    logic               out_free;

    assign sample = CMP_W'(s_tdata[SAMPLE_BITS-1:0]);
    assign thresh = (min_reg == '0) ? CMP_W'(1) : CMP_W'(min_reg);
    assign below  = sample < thresh;
    // A record start latches max(sample, threshold) as the new reference.
    assign log_in = (s_tuser && below) ? thresh : sample;

    // Binary search for the leading one: shifts of 16, 8, 4, 2 and 1.
    assign amt      = EXP_W'((MANT_W / 2) >> cnt_reg);
    assign m_shift  = m_reg << amt;
    assign top_zero = (m_shift >> amt) == m_reg;
    assign e_val    = EXP_W'(MANT_W - 1) - lz_reg;

    // Each square is renormalized to Q1.31; the carry out is the next log bit.
    assign mm      = prod_reg[PROD_W-1:MANT_W-1];
    assign sq_bit  = mm[MANT_W];
    assign sq_norm = sq_bit ? mm[MANT_W:1] : mm[MANT_W-1:0];
    assign sq_in   = (cnt_reg == '0) ? m_reg : sq_norm;
    assign f_shift = {f_reg[LOG_FRAC-2:0], sq_bit};
    assign lb      = {e_val, f_reg};

    always_comb begin
        if (state_reg == ST_MUL) begin
            mul_a = mag_reg;
            mul_b = LOG10_2_Q30;
        end else begin
            mul_a = LOG_W'(sq_in);
            mul_b = sq_in;
        end
    end

    assign mul_p = mul_a * mul_b;

    assign rnd_sum  = {1'b0, prod_reg} + ((PROD_W + 1)'(1) << (RND_SHIFT - 1));
    assign rnd      = rnd_sum[PROD_W:RND_SHIFT];
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        min_next      = min_reg;
        cnt_next      = cnt_reg;
        m_next        = m_reg;
        lz_next       = lz_reg;
        f_next        = f_reg;
        prod_next     = prod_reg;
        la_next       = la_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        sat_next      = sat_reg;
        zero_next     = zero_reg;
        start_next    = start_reg;
        od_next       = od_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;

        if (cfg_valid) begin
            min_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    m_next     = MANT_W'(log_in);
                    start_next = s_tuser;
                    // Start words and words below threshold both give zero.
                    zero_next  = s_tuser || below;
                    cnt_next   = '0;
                    lz_next    = '0;
                    if (s_tuser || !below) begin
                        state_next = ST_NORM;
                    end else begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_NORM: begin
                if (top_zero) begin
                    m_next  = m_shift;
                    lz_next = lz_reg + amt;
                end
                if (cnt_reg == CNT_W'(EXP_W - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_SQR;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SQR: begin
                prod_next = mul_p[PROD_W-1:0];
                if (cnt_reg != '0) begin
                    f_next = f_shift;
                end
                if (cnt_reg == CNT_W'(LOG_FRAC)) begin
                    cnt_next = '0;
                    if (start_reg) begin
                        // Cache log2 of the new reference for later samples.
                        la_next    = {e_val, f_shift};
                        state_next = ST_WRITE;
                    end else begin
                        state_next = ST_DIFF;
                    end
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIFF: begin
                neg_next   = la_reg < lb;
                mag_next   = (la_reg < lb) ? (lb - la_reg) : (la_reg - lb);
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_next  = mul_p[PROD_W-1:0];
                state_next = ST_RND;
            end
            ST_RND: begin
                if (neg_reg) begin
                    sat_next = (rnd > RND_W'(NEG_MAX)) ? NEG_MAX : rnd[OUT_W-1:0];
                end else begin
                    sat_next = (rnd > RND_W'(POS_MAX)) ? POS_MAX : rnd[OUT_W-1:0];
                end
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (out_free) begin
                    if (zero_reg) begin
                        od_next = '0;
                    end else if (neg_reg) begin
                        od_next = OUT_W'(0) - sat_reg;
                    end else begin
                        od_next = sat_reg;
                    end
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            min_reg      <= CFG_W'(1);
            // log2 of the reset reference, one, is exactly zero.
            la_reg       <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            min_reg      <= min_next;
            la_reg       <= la_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_reg     <= m_next;
        lz_reg    <= lz_next;
        f_reg     <= f_next;
        prod_reg  <= prod_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        sat_reg   <= sat_next;
        zero_reg  <= zero_next;
        start_reg <= start_next;
        od_reg    <= od_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {(OUT_TDATA_W - OUT_W)'(0), od_reg};

    // The squaring loop always works on a normalized mantissa.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQR) |-> sq_in[MANT_W-1])
        else $error("squaring operand lost its leading one");

    // The exponent of a sample never exceeds the sample width.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIFF) |-> (e_val < EXP_W'(CMP_W)))
        else $error("log2 exponent out of range");

    // Leaving the write state always presents a result word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && out_free) |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("result word not presented");

    // A new sample is never taken while the sequencer is busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("ready raised while busy");

endmodule

`default_nettype wire
